[hdl/integer_to_radix_ascii_assert.svh]
// Assertion macros shared by the integer to radix ASCII RTL.
`ifndef INTEGER_TO_RADIX_ASCII_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_ASSERT_SVH
`ifndef SYNTH
`define ITRA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("itra assertion failed");
`define ITRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("itra assertion failed");
`else
`define ITRA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ITRA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/itra_pkg.sv]
// Shared constants, types and the digit character table.
package itra_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int RADIX_W        = 5;
	localparam int CH_W           = 7;
	localparam int DIGIT_W        = 4;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
	localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;

	localparam logic [CH_W-1:0] CH_MINUS = 7'h2d;

	localparam logic [CH_W-1:0] DIGIT_CHARS [16] = '{
		7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
		7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
	};

	// start request to the divider
	typedef struct packed {
		logic               start;
		logic [RADIX_W-1:0] divisor;
	} div_req_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic               busy;
		logic               done;
		logic [DIGIT_W-1:0] rem;
	} div_rsp_t;

	function automatic logic [CH_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		return DIGIT_CHARS[d];
	endfunction

endpackage

[hdl/itra_if.sv]
// Valid/ready channel interfaces for the input and result words.
interface itra_in_if #(
	parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;
	logic [itra_pkg::RADIX_W-1:0] radix;

	modport source (output valid, output value, output radix, input ready);
	modport sink   (input valid, input value, input radix, output ready);
endinterface

interface itra_out_if;
	logic                      valid;
	logic                      ready;
	logic [itra_pkg::CH_W-1:0] ch;
	logic                      last;

	modport source (output valid, output ch, output last, input ready);
	modport sink   (input valid, input ch, input last, output ready);
endinterface

[hdl/itra_divider.sv]
// Bit-serial restoring divider by a small radix, one quotient bit per cycle.
`include "integer_to_radix_ascii_assert.svh"

module itra_divider #(
	parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  itra_pkg::div_req_t     req,
	input  logic [VALUE_BITS-1:0]  dividend,
	output itra_pkg::div_rsp_t     rsp,
	output logic [VALUE_BITS-1:0]  quotient
);

	localparam int CNT_W = $clog2(VALUE_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

	logic                             busy_q;
	logic                             done_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [VALUE_BITS-1:0]            quo_q;
	logic [itra_pkg::DIGIT_W-1:0]     rem_q;
	logic [itra_pkg::RADIX_W-1:0]     divisor_q;

	logic [itra_pkg::RADIX_W-1:0]     trial;
	logic                             ge;
	logic [itra_pkg::RADIX_W-1:0]     diff;

	// partial remainder stays below the divisor, so it fits in four bits
	assign trial = {rem_q, quo_q[VALUE_BITS-1]};
	assign ge    = trial >= divisor_q;
	assign diff  = trial - divisor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
			rem_q <= ge ? diff[itra_pkg::DIGIT_W-1:0] : trial[itra_pkg::DIGIT_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;
	assign quotient = quo_q;

	`ITRA_ASSERT_NEXT(a_start_busy, clk, arst_n, req.start, busy_q)
	`ITRA_ASSERT_NEXT(a_end_done, clk, arst_n, busy_q && cnt_q == '0 && !req.start, done_q)
	`ITRA_ASSERT_IMPLY(a_rem_small, clk, arst_n, done_q, ({1'b0, rem_q} < divisor_q))

endmodule

[hdl/itra_digit_mem.sv]
// Digit store, one write and one registered read port.
module itra_digit_mem #(
	parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [$clog2(VALUE_BITS)-1:0]     wr_addr,
	input  logic [itra_pkg::DIGIT_W-1:0]      wr_data,
	input  logic                              rd_en,
	input  logic [$clog2(VALUE_BITS)-1:0]     rd_addr,
	output logic [itra_pkg::DIGIT_W-1:0]      rd_data
);

	logic [itra_pkg::DIGIT_W-1:0] mem [VALUE_BITS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hdl/integer_to_radix_ascii.sv]
// Top level: integer to ASCII text in radix 2 to 16, digits most significant first.
//
// din carries one word: value (VALUE_BITS, two's complement) and radix (5 bits).
// Radix below 2 is taken as 2, above 16 as 16. Radix 10 is signed: negatives
// give a leading '-' and then the magnitude; other radices read the value as
// unsigned. dout carries one character per word, with last set on the final one.
// Both channels use valid/ready; a word moves when both are high.
// Digits come from repeated division by the radix in one bit-serial divider,
// which runs once per digit. Each character is then read back through the
// digit store's registered read port. din is ready only while no item is in
// work; the output register lets the next item enter while the final
// character still waits. A stalled receiver holds dout steady and pauses
// emission. Reset (arst_n low) returns the sequencer to idle and drops
// dout.valid; the digit store needs no clearing since every item writes
// before it reads.
`include "integer_to_radix_ascii_assert.svh"

module integer_to_radix_ascii #(
	parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	itra_in_if.sink    din,
	itra_out_if.source dout
);

	localparam int AW = $clog2(VALUE_BITS);
	localparam int CW = $clog2(VALUE_BITS + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_SIGN = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_PUT  = 3'd4;

	logic [2:0]                    state_q;
	logic                          neg_q;
	logic [CW-1:0]                 cnt_q;
	logic [itra_pkg::RADIX_W-1:0]  radix_q;
	logic                          out_valid_q;
	logic [itra_pkg::CH_W-1:0]     out_ch_q;
	logic                          out_last_q;

	logic                          accept;
	logic                          out_free;
	logic [itra_pkg::RADIX_W-1:0]  radix_c;
	logic                          neg_c;
	logic [VALUE_BITS-1:0]         mag_c;

	itra_pkg::div_req_t            div_req;
	itra_pkg::div_rsp_t            div_rsp;
	logic [VALUE_BITS-1:0]         div_dividend;
	logic [VALUE_BITS-1:0]         div_quo;
	logic                          quo_zero;

	logic                          mem_wr;
	logic                          mem_rd;
	logic [AW-1:0]                 rd_addr;
	logic [itra_pkg::DIGIT_W-1:0]  rd_data;

	assign accept   = din.valid && din.ready;
	assign din.ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || dout.ready;
	assign quo_zero = (div_quo == '0);

	// radix clamp and decimal sign handling
	always_comb begin
		radix_c = din.radix;
		if (din.radix inside {[5'd0:5'd1]}) begin
			radix_c = itra_pkg::RADIX_MIN;
		end else if (din.radix inside {[5'd17:5'd31]}) begin
			radix_c = itra_pkg::RADIX_MAX;
		end
		neg_c = (radix_c == itra_pkg::RADIX_DEC) && din.value[VALUE_BITS-1];
		mag_c = neg_c ? (VALUE_BITS'(0) - VALUE_BITS'(din.value)) : VALUE_BITS'(din.value);
	end

	// divider start: first digit on accept, following ones from the quotient
	always_comb begin
		div_req.start   = 1'b0;
		div_req.divisor = radix_q;
		div_dividend    = div_quo;
		if (accept) begin
			div_req.start   = 1'b1;
			div_req.divisor = radix_c;
			div_dividend    = mag_c;
		end else if (state_q == S_DIV && div_rsp.done && !quo_zero) begin
			div_req.start = 1'b1;
		end
	end

	assign mem_wr  = (state_q == S_DIV) && div_rsp.done;
	assign mem_rd  = (state_q == S_RD);
	assign rd_addr = AW'(cnt_q - 1'b1);

	itra_divider #(
		.VALUE_BITS (VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.rsp      (div_rsp),
		.quotient (div_quo)
	);

	itra_digit_mem #(
		.VALUE_BITS (VALUE_BITS)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (div_rsp.rem),
		.rd_en   (mem_rd),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// sequencer and digit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
			radix_q <= itra_pkg::RADIX_MIN;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DIV;
						neg_q   <= neg_c;
						cnt_q   <= '0;
						radix_q <= radix_c;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						cnt_q <= cnt_q + 1'b1;
						if (quo_zero) begin
							state_q <= neg_q ? S_SIGN : S_RD;
						end
					end
				end
				S_SIGN: begin
					if (out_free) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (out_free) begin
						state_q <= (cnt_q == '0) ? S_IDLE : S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == S_SIGN) || (state_q == S_PUT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == S_SIGN) begin
				out_ch_q   <= itra_pkg::CH_MINUS;
				out_last_q <= 1'b0;
			end else if (state_q == S_PUT) begin
				out_ch_q   <= itra_pkg::digit_char(rd_data);
				out_last_q <= (cnt_q == '0);
			end
		end
	end

	assign dout.valid = out_valid_q;
	assign dout.ch    = out_ch_q;
	assign dout.last  = out_last_q;

	`ITRA_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q == S_DIV)
	`ITRA_ASSERT_IMPLY(a_idle_div, clk, arst_n, state_q == S_IDLE, !div_rsp.busy)
	`ITRA_ASSERT_IMPLY(a_done_in_div, clk, arst_n, div_rsp.done, state_q == S_DIV)
	`ITRA_ASSERT_IMPLY(a_no_overflow, clk, arst_n, state_q == S_DIV, cnt_q < CW'(VALUE_BITS))

endmodule
